// ===== src/assert_macros.svh =====
// Assertion helpers shared by the divider and pack RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/pdir_pkg.sv =====
package pdir_pkg;

   // width of coordinates and direction components
   localparam int COORD_W = 16;
   // default number of fraction bits
   localparam int COORD_FRAC_BITS_DEF = 15;
   // width of a squared coordinate magnitude
   localparam int SQ_W = 2 * COORD_W;
   // quotient bits kept: enough to round and to detect saturation
   localparam int QUOT_W = COORD_W + 2;

   // per-request side information carried along the pipeline
   typedef struct packed {
      logic face;
      logic neg_u;
      logic neg_v;
      logic in_disk;
   } pdir_side_type;

endpackage

// ===== src/pdir_square.sv =====
module pdir_square #(
   parameter int FRAC_BITS = pdir_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic                                in_face,
   input  logic signed [pdir_pkg::COORD_W-1:0] in_u,
   input  logic signed [pdir_pkg::COORD_W-1:0] in_v,
   output logic                                out_valid,
   input  logic                                out_ready,
   output pdir_pkg::pdir_side_type             out_side,
   output logic [pdir_pkg::COORD_W-1:0]        out_au,
   output logic [pdir_pkg::COORD_W-1:0]        out_av,
   output logic [2*FRAC_BITS+1:0]              out_den,
   output logic [2*FRAC_BITS:0]                out_az
);
   import pdir_pkg::*;

   localparam int DEN_W = 2 * FRAC_BITS + 2;
   localparam int AZ_W  = 2 * FRAC_BITS + 1;
   localparam int ACC_W = (DEN_W > SQ_W + 1) ? DEN_W : SQ_W + 1;
   localparam logic [ACC_W-1:0] ONE_SQ = ACC_W'(1) << (2 * FRAC_BITS);

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic rdy1, rdy2, rdy3;

   logic [COORD_W-1:0] u_bits, v_bits;
   logic [COORD_W-1:0] s1_au_in, s1_av_in;
   logic [COORD_W-1:0] s1_au_ff, s1_av_ff, s2_au_ff, s2_av_ff, s3_au_ff, s3_av_ff;
   pdir_side_type      s1_side_in, s1_side_ff, s2_side_ff, s3_side_in, s3_side_ff;
   logic [SQ_W-1:0]    s2_squ_in, s2_sqv_in, s2_squ_ff, s2_sqv_ff;
   logic [SQ_W-1:0]    r2;
   logic [ACC_W-1:0]   r2_ext;
   logic [DEN_W-1:0]   s3_den_in, s3_den_ff;
   logic [AZ_W-1:0]    s3_az_in, s3_az_ff;

   // bubble-collapsing ready chain
   assign rdy3     = !s3_vld_ff || out_ready;
   assign rdy2     = !s2_vld_ff || rdy3;
   assign rdy1     = !s1_vld_ff || rdy2;
   assign in_ready = rdy1;

   // stage 1: magnitudes and signs
   assign u_bits   = in_u;
   assign v_bits   = in_v;
   assign s1_au_in = u_bits[COORD_W-1] ? (~u_bits + COORD_W'(1)) : u_bits;
   assign s1_av_in = v_bits[COORD_W-1] ? (~v_bits + COORD_W'(1)) : v_bits;

   always_comb begin
      s1_side_in.face    = in_face;
      s1_side_in.neg_u   = u_bits[COORD_W-1];
      s1_side_in.neg_v   = v_bits[COORD_W-1];
      s1_side_in.in_disk = 1'b0;
   end

   // stage 2: squares
   assign s2_squ_in = SQ_W'(s1_au_ff) * SQ_W'(s1_au_ff);
   assign s2_sqv_in = SQ_W'(s1_av_ff) * SQ_W'(s1_av_ff);

   // stage 3: radius squared, disk test, denominator and z numerator
   assign r2        = s2_squ_ff + s2_sqv_ff;
   assign r2_ext    = ACC_W'(r2);
   assign s3_den_in = DEN_W'(ONE_SQ + r2_ext);
   assign s3_az_in  = AZ_W'(ONE_SQ - r2_ext);

   always_comb begin
      s3_side_in         = s2_side_ff;
      s3_side_in.in_disk = (r2_ext <= ONE_SQ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (rdy1) s1_vld_ff <= in_valid;
         if (rdy2) s2_vld_ff <= s1_vld_ff;
         if (rdy3) s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_au_ff   <= s1_au_in;
         s1_av_ff   <= s1_av_in;
         s1_side_ff <= s1_side_in;
      end
      if (rdy2) begin
         s2_au_ff   <= s1_au_ff;
         s2_av_ff   <= s1_av_ff;
         s2_squ_ff  <= s2_squ_in;
         s2_sqv_ff  <= s2_sqv_in;
         s2_side_ff <= s1_side_ff;
      end
      if (rdy3) begin
         s3_au_ff   <= s2_au_ff;
         s3_av_ff   <= s2_av_ff;
         s3_den_ff  <= s3_den_in;
         s3_az_ff   <= s3_az_in;
         s3_side_ff <= s3_side_in;
      end
   end

   assign out_valid = s3_vld_ff;
   assign out_side  = s3_side_ff;
   assign out_au    = s3_au_ff;
   assign out_av    = s3_av_ff;
   assign out_den   = s3_den_ff;
   assign out_az    = s3_az_ff;

endmodule

// ===== src/pdir_div.sv =====
`include "assert_macros.svh"

module pdir_div #(
   parameter int FRAC_BITS = pdir_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  pdir_pkg::pdir_side_type       in_side,
   input  logic [pdir_pkg::COORD_W-1:0]  in_au,
   input  logic [pdir_pkg::COORD_W-1:0]  in_av,
   input  logic [2*FRAC_BITS+1:0]        in_den,
   input  logic [2*FRAC_BITS:0]          in_az,
   output logic                          out_valid,
   input  logic                          out_ready,
   output pdir_pkg::pdir_side_type       out_side,
   output logic [pdir_pkg::QUOT_W-1:0]   out_qx,
   output logic [pdir_pkg::QUOT_W-1:0]   out_qy,
   output logic [pdir_pkg::QUOT_W-1:0]   out_qz,
   output logic                          out_ovz
);
   import pdir_pkg::*;

   localparam int DEN_W = 2 * FRAC_BITS + 2;
   localparam int XN_W  = COORD_W + DEN_W;          // 2u * 2^(2F+1)
   localparam int ZN_W  = 3 * FRAC_BITS + 2;        // (1 - r2) * 2^(F+1)
   localparam int ZT_W  = ZN_W - QUOT_W;
   localparam int TZ_W  = (ZT_W > DEN_W) ? ZT_W : DEN_W;
   localparam logic [QUOT_W-1:0] XY_QMAX = QUOT_W'(1) << (QUOT_W - 1);

   // one restoring step: {quotient bit, next remainder}
   function automatic logic [DEN_W:0] div_step(logic [DEN_W-1:0] rem, logic bit_in,
                                                logic [DEN_W-1:0] den);
      logic [DEN_W:0] wide;
      logic [DEN_W:0] diff;
      wide = {rem, bit_in};
      diff = wide - {1'b0, den};
      if (wide >= {1'b0, den}) begin
         return {1'b1, diff[DEN_W-1:0]};
      end
      return {1'b0, wide[DEN_W-1:0]};
   endfunction

   logic [QUOT_W:0]    vld_ff;
   logic [QUOT_W:0]    rdy;
   pdir_side_type      side_ff  [0:QUOT_W];
   logic [DEN_W-1:0]   den_ff   [0:QUOT_W];
   logic [DEN_W-1:0]   remx_ff  [0:QUOT_W];
   logic [DEN_W-1:0]   remy_ff  [0:QUOT_W];
   logic [DEN_W-1:0]   remz_ff  [0:QUOT_W];
   logic [QUOT_W-1:0]  qx_ff    [0:QUOT_W];
   logic [QUOT_W-1:0]  qy_ff    [0:QUOT_W];
   logic [QUOT_W-1:0]  qz_ff    [0:QUOT_W];
   logic [QUOT_W-1:0]  zlow_ff  [0:QUOT_W];
   logic               ovz_ff   [0:QUOT_W];

   logic [DEN_W:0]     stx [1:QUOT_W];
   logic [DEN_W:0]     sty [1:QUOT_W];
   logic [DEN_W:0]     stz [1:QUOT_W];

   logic [XN_W-1:0]    nx, ny;
   logic [ZN_W-1:0]    nz;
   logic [TZ_W-1:0]    topz_ext;
   logic [DEN_W-1:0]   remx_in, remy_in, remz_in;
   logic               ovz_in;

   // ready chain, last stage first
   assign rdy[QUOT_W] = !vld_ff[QUOT_W] || out_ready;
   for (genvar g = 0; g < QUOT_W; g++) begin : g_rdy
      assign rdy[g] = !vld_ff[g] || rdy[g+1];
   end
   assign in_ready = rdy[0];

   // entry stage: align numerators, z overflow check
   assign nx       = {in_au, {DEN_W{1'b0}}};
   assign ny       = {in_av, {DEN_W{1'b0}}};
   assign nz       = {in_az, {(FRAC_BITS + 1){1'b0}}};
   assign topz_ext = TZ_W'(nz[ZN_W-1:QUOT_W]);
   assign remx_in  = DEN_W'(nx[XN_W-1:QUOT_W]);
   assign remy_in  = DEN_W'(ny[XN_W-1:QUOT_W]);
   assign remz_in  = topz_ext[DEN_W-1:0];
   assign ovz_in   = (topz_ext >= TZ_W'(in_den));

   // one quotient bit per stage for each lane
   always_comb begin
      for (int k = 1; k <= QUOT_W; k++) begin
         stx[k] = div_step(remx_ff[k-1], 1'b0, den_ff[k-1]);
         sty[k] = div_step(remy_ff[k-1], 1'b0, den_ff[k-1]);
         stz[k] = div_step(remz_ff[k-1], zlow_ff[k-1][QUOT_W-1], den_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k <= QUOT_W; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         side_ff[0] <= in_side;
         den_ff[0]  <= in_den;
         remx_ff[0] <= remx_in;
         remy_ff[0] <= remy_in;
         remz_ff[0] <= remz_in;
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         qz_ff[0]   <= '0;
         zlow_ff[0] <= nz[QUOT_W-1:0];
         ovz_ff[0]  <= ovz_in;
      end
      for (int k = 1; k <= QUOT_W; k++) begin
         if (rdy[k]) begin
            side_ff[k] <= side_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            remx_ff[k] <= stx[k][DEN_W-1:0];
            remy_ff[k] <= sty[k][DEN_W-1:0];
            remz_ff[k] <= stz[k][DEN_W-1:0];
            qx_ff[k]   <= {qx_ff[k-1][QUOT_W-2:0], stx[k][DEN_W]};
            qy_ff[k]   <= {qy_ff[k-1][QUOT_W-2:0], sty[k][DEN_W]};
            qz_ff[k]   <= {qz_ff[k-1][QUOT_W-2:0], stz[k][DEN_W]};
            zlow_ff[k] <= {zlow_ff[k-1][QUOT_W-2:0], 1'b0};
            ovz_ff[k]  <= ovz_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[QUOT_W];
   assign out_side  = side_ff[QUOT_W];
   assign out_qx    = qx_ff[QUOT_W];
   assign out_qy    = qy_ff[QUOT_W];
   assign out_qz    = qz_ff[QUOT_W];
   assign out_ovz   = ovz_ff[QUOT_W];

   // a stalled result keeps its quotient
   `ASSERT_NEXT(a_div_hold, clock, reset, out_valid && !out_ready, out_valid && $stable(out_qx), "div: stalled quotient changed")
   // x and y quotients never exceed 2^(QUOT_W-1) inside the disk
   `ASSERT_IMPLIES(a_div_xy_bound, clock, reset, out_valid && out_side.in_disk, (out_qx <= XY_QMAX) && (out_qy <= XY_QMAX), "div: x/y quotient out of range")
   // z cannot overflow the kept quotient bits at narrow fractions
   `ASSERT_IMPLIES(a_div_z_fit, clock, reset, out_valid && out_side.in_disk && (FRAC_BITS <= COORD_W), !out_ovz, "div: unexpected z overflow")

endmodule

// ===== src/pdir_pack.sv =====
`include "assert_macros.svh"

module pdir_pack (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  pdir_pkg::pdir_side_type             in_side,
   input  logic [pdir_pkg::QUOT_W-1:0]         in_qx,
   input  logic [pdir_pkg::QUOT_W-1:0]         in_qy,
   input  logic [pdir_pkg::QUOT_W-1:0]         in_qz,
   input  logic                                in_ovz,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [pdir_pkg::COORD_W-1:0] out_dir_x,
   output logic signed [pdir_pkg::COORD_W-1:0] out_dir_y,
   output logic signed [pdir_pkg::COORD_W-1:0] out_dir_z,
   output logic                                out_valid_res
);
   import pdir_pkg::*;

   localparam logic [QUOT_W-1:0] POS_LIM = QUOT_W'((1 << (COORD_W - 1)) - 1);
   localparam logic [QUOT_W-1:0] NEG_LIM = QUOT_W'(1 << (COORD_W - 1));
   localparam logic [COORD_W-1:0] POS_SAT = {1'b0, {(COORD_W - 1){1'b1}}};
   localparam logic [COORD_W-1:0] NEG_SAT = {1'b1, {(COORD_W - 1){1'b0}}};

   // round half up, apply sign, saturate
   function automatic logic [COORD_W-1:0] to_comp(logic [QUOT_W-1:0] q, logic neg, logic ovf);
      logic [QUOT_W:0]   q_inc;
      logic [QUOT_W-1:0] mag;
      q_inc = {1'b0, q} + (QUOT_W + 1)'(1);
      mag   = q_inc[QUOT_W:1];
      if (ovf) begin
         return neg ? NEG_SAT : POS_SAT;
      end
      if (!neg) begin
         return (mag > POS_LIM) ? POS_SAT : mag[COORD_W-1:0];
      end
      return (mag > NEG_LIM) ? NEG_SAT : (~mag[COORD_W-1:0] + COORD_W'(1));
   endfunction

   logic               out_vld_ff;
   logic [COORD_W-1:0] dir_x_in, dir_y_in, dir_z_in;
   logic [COORD_W-1:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic               valid_res_ff;

   assign in_ready = !out_vld_ff || out_ready;

   // outside the disk every component is zero
   always_comb begin
      dir_x_in = '0;
      dir_y_in = '0;
      dir_z_in = '0;
      if (in_side.in_disk) begin
         dir_x_in = to_comp(in_qx, in_side.neg_u ^ in_side.face, 1'b0);
         dir_y_in = to_comp(in_qy, in_side.neg_v ^ in_side.face, 1'b0);
         dir_z_in = to_comp(in_qz, in_side.face, in_ovz);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (in_ready) begin
         out_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         dir_x_ff     <= dir_x_in;
         dir_y_ff     <= dir_y_in;
         dir_z_ff     <= dir_z_in;
         valid_res_ff <= in_side.in_disk;
      end
   end

   assign out_valid     = out_vld_ff;
   assign out_dir_x     = dir_x_ff;
   assign out_dir_y     = dir_y_ff;
   assign out_dir_z     = dir_z_ff;
   assign out_valid_res = valid_res_ff;

   // a point outside the disk gives a zero direction
   `ASSERT_IMPLIES(a_pack_zero, clock, reset, out_valid && !out_valid_res, (out_dir_x == '0) && (out_dir_y == '0) && (out_dir_z == '0), "pack: nonzero direction outside disk")
   // front face points toward nonnegative z
   `ASSERT_NEXT(a_pack_front_z, clock, reset, in_valid && in_ready && in_side.in_disk && !in_side.face, !out_dir_z[COORD_W-1], "pack: front face z negative")
   // back face points toward nonpositive z
   `ASSERT_NEXT(a_pack_back_z, clock, reset, in_valid && in_ready && in_side.in_disk && in_side.face, out_dir_z[COORD_W-1] || (out_dir_z == '0), "pack: back face z positive")

endmodule

// ===== src/paraboloid_uv_to_direction.sv =====
// Pipeline: 23 register stages (3 square/sum stages, 1 alignment stage, 18 divider
//   stages at one quotient bit each, 1 output stage).
// Throughput: one request per clock; each stage stalls only when the stage after it is full.
// The three direction components are divided in parallel lanes of the same pipeline.
// Reset (synchronous, active high) clears all stage valid bits; payload is not reset.
module paraboloid_uv_to_direction #(
   parameter int COORD_FRAC_BITS = pdir_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_face,
   input  logic signed [pdir_pkg::COORD_W-1:0] req_u_coord,
   input  logic signed [pdir_pkg::COORD_W-1:0] req_v_coord,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pdir_pkg::COORD_W-1:0] rsp_dir_x,
   output logic signed [pdir_pkg::COORD_W-1:0] rsp_dir_y,
   output logic signed [pdir_pkg::COORD_W-1:0] rsp_dir_z,
   output logic                                rsp_valid_res
);
   import pdir_pkg::*;

   localparam int DEN_W = 2 * COORD_FRAC_BITS + 2;
   localparam int AZ_W  = 2 * COORD_FRAC_BITS + 1;

   logic               sq_valid, sq_ready;
   pdir_side_type      sq_side;
   logic [COORD_W-1:0] sq_au, sq_av;
   logic [DEN_W-1:0]   sq_den;
   logic [AZ_W-1:0]    sq_az;

   logic               dv_valid, dv_ready;
   pdir_side_type      dv_side;
   logic [QUOT_W-1:0]  dv_qx, dv_qy, dv_qz;
   logic               dv_ovz;

   // magnitudes, squares, denominator
   pdir_square #(
      .FRAC_BITS (COORD_FRAC_BITS)
   ) u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_face   (req_face),
      .in_u      (req_u_coord),
      .in_v      (req_v_coord),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_side  (sq_side),
      .out_au    (sq_au),
      .out_av    (sq_av),
      .out_den   (sq_den),
      .out_az    (sq_az)
   );

   // pipelined long division, three lanes
   pdir_div #(
      .FRAC_BITS (COORD_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_side   (sq_side),
      .in_au     (sq_au),
      .in_av     (sq_av),
      .in_den    (sq_den),
      .in_az     (sq_az),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_side  (dv_side),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy),
      .out_qz    (dv_qz),
      .out_ovz   (dv_ovz)
   );

   // rounding, sign, saturation, output register
   pdir_pack u_pack (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (dv_valid),
      .in_ready      (dv_ready),
      .in_side       (dv_side),
      .in_qx         (dv_qx),
      .in_qy         (dv_qy),
      .in_qz         (dv_qz),
      .in_ovz        (dv_ovz),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_dir_x     (rsp_dir_x),
      .out_dir_y     (rsp_dir_y),
      .out_dir_z     (rsp_dir_z),
      .out_valid_res (rsp_valid_res)
   );

endmodule
